### hdl/uoha_pkg.sv
package uoha_pkg;

  localparam int PIX_W = 32;
  localparam int OX_W = 12;
  localparam int OY_W = 13;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam int FW_W = 12;
  localparam int FH_W = 13;
  localparam int FW_RESET = 2048;
  localparam int FH_RESET = 4096;
  localparam int LIM_W = 14;

  localparam logic [PIX_W-1:0] MASK_XRGB = 32'h0101_0101;
  localparam logic [15:0]      MASK_565  = 16'h0821;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_LW = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] d;
    logic [OX_W-1:0]  bx;
    logic [OY_W-1:0]  by;
  } job_t;

  typedef struct packed {
    logic            vld;
    logic [Q_LW-1:0] level;
  } q_stat_t;

  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] p,
                                             input logic [PIX_W-1:0] q,
                                             input logic fmt565);
    logic [16:0]      s16;
    logic [PIX_W-1:0] s32;
    s16 = {1'b0, p[15:0]} + {1'b0, q[15:0]} + {1'b0, (p[15:0] ^ q[15:0]) & MASK_565};
    s32 = p + q + ((p ^ q) & MASK_XRGB);
    if (fmt565) begin
      return {16'h0000, s16[16:1]};
    end else begin
      return {1'b0, s32[PIX_W-1:1]};
    end
  endfunction

endpackage

### hdl/uoha_front.sv
module uoha_front #(
  parameter int MAX_LINE_PIX = 2048,
  parameter int MAX_LINES    = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [uoha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uoha_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [uoha_pkg::PIX_W-1:0]      in_pixel_in,
  input  uoha_pkg::q_stat_t               q_stat,
  output logic                            job_push,
  output uoha_pkg::job_t                  job,
  output logic                            fmt565
);

  localparam int XW = $clog2(MAX_LINE_PIX);
  localparam int YW = $clog2(MAX_LINES);
  localparam int LW = uoha_pkg::LIM_W;
  localparam int W_RST = (uoha_pkg::FW_RESET > MAX_LINE_PIX) ? MAX_LINE_PIX
                                                             : uoha_pkg::FW_RESET;
  localparam int H_RST = (uoha_pkg::FH_RESET > MAX_LINES) ? MAX_LINES : uoha_pkg::FH_RESET;

  logic [uoha_pkg::PIX_W-1:0] mem [MAX_LINE_PIX];

  logic                       fmt_r;
  logic [XW-1:0]              wlast_r, wlast_nxt;
  logic [YW-1:0]              hlast_r, hlast_nxt;
  logic [XW-1:0]              x_r, x_nxt;
  logic [YW-1:0]              y_r, y_nxt;
  logic                       s1_vld_r;
  logic [uoha_pkg::PIX_W-1:0] a_r, b_r, c_r, d_r;
  logic [uoha_pkg::OX_W-1:0]  bx_r;
  logic [uoha_pkg::OY_W-1:0]  by_r;

  logic                       accept, st_we, c_we, tile;
  logic                       known_reg;
  logic [uoha_pkg::PIX_W-1:0] pix;
  logic [LW-1:0]              fw, fh;
  logic [uoha_pkg::OX_W-1:0]  xh;
  logic [uoha_pkg::OY_W-1:0]  yh;

  assign full = s1_vld_r ? (q_stat.level >= uoha_pkg::Q_LW'(uoha_pkg::Q_DEPTH - 1))
                         : (q_stat.level >= uoha_pkg::Q_LW'(uoha_pkg::Q_DEPTH));
  assign accept = push && !full;
  assign pix    = fmt_r ? {16'h0000, in_pixel_in[15:0]} : in_pixel_in;
  assign st_we  = accept && !y_r[0];
  assign c_we   = accept && y_r[0] && !x_r[0];
  assign tile   = accept && y_r[0] && x_r[0];

  assign xh = uoha_pkg::OX_W'(x_r >> 1);
  assign yh = uoha_pkg::OY_W'(y_r >> 1);

  assign fw = LW'(cfg_data[uoha_pkg::FW_W-1:0]);
  assign fh = LW'(cfg_data[uoha_pkg::FH_W-1:0]);

  always_comb begin
    if (fw == '0) begin
      wlast_nxt = '0;
    end else if (fw > LW'(MAX_LINE_PIX)) begin
      wlast_nxt = XW'(MAX_LINE_PIX - 1);
    end else begin
      wlast_nxt = XW'(fw - LW'(1));
    end
    if (fh == '0) begin
      hlast_nxt = '0;
    end else if (fh > LW'(MAX_LINES)) begin
      hlast_nxt = YW'(MAX_LINES - 1);
    end else begin
      hlast_nxt = YW'(fh - LW'(1));
    end
  end

  always_comb begin
    known_reg = (cfg_index == uoha_pkg::REG_FORMAT) || (cfg_index == uoha_pkg::REG_WIDTH) ||
                (cfg_index == uoha_pkg::REG_HEIGHT);
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (cfg_we && known_reg) begin
      x_nxt = '0;
      y_nxt = '0;
    end else if (accept) begin
      if (x_r == wlast_r) begin
        x_nxt = '0;
        y_nxt = (y_r == hlast_r) ? '0 : y_r + YW'(1);
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= 1'b0;
      wlast_r  <= XW'(W_RST - 1);
      hlast_r  <= YW'(H_RST - 1);
      x_r      <= '0;
      y_r      <= '0;
      s1_vld_r <= 1'b0;
      c_r      <= '0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      s1_vld_r <= tile;
      if (c_we) begin
        c_r <= pix;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          uoha_pkg::REG_FORMAT: fmt_r   <= cfg_data[0];
          uoha_pkg::REG_WIDTH:  wlast_r <= wlast_nxt;
          uoha_pkg::REG_HEIGHT: hlast_r <= hlast_nxt;
          default: ;
        endcase
      end
    end
  end

  // line store of the even row
  always_ff @(posedge clk) begin
    if (st_we) begin
      mem[x_r] <= pix;
    end
    if (tile) begin
      a_r <= mem[x_r - XW'(1)];
      b_r <= mem[x_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tile) begin
      d_r  <= pix;
      bx_r <= xh + (xh << 1);
      by_r <= yh + (yh << 1);
    end
  end

  assign job_push = s1_vld_r;
  assign job.a    = a_r;
  assign job.b    = b_r;
  assign job.c    = c_r;
  assign job.d    = d_r;
  assign job.bx   = bx_r;
  assign job.by   = by_r;
  assign fmt565   = fmt_r;

endmodule

### hdl/uoha_queue.sv
module uoha_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  uoha_pkg::job_t    wr_job,
  input  logic              rd,
  output uoha_pkg::job_t    rd_job,
  output uoha_pkg::q_stat_t stat
);

  uoha_pkg::job_t                ent_r [uoha_pkg::Q_DEPTH];
  logic [uoha_pkg::Q_AW-1:0]     wp_r, rp_r;
  logic [uoha_pkg::Q_LW-1:0]     lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + uoha_pkg::Q_AW'(1);
      end
      if (rd) begin
        rp_r <= rp_r + uoha_pkg::Q_AW'(1);
      end
      priority if (wr && !rd) begin
        lvl_r <= lvl_r + uoha_pkg::Q_LW'(1);
      end else if (rd && !wr) begin
        lvl_r <= lvl_r - uoha_pkg::Q_LW'(1);
      end else begin
        lvl_r <= lvl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_r[wp_r] <= wr_job;
    end
  end

  assign rd_job     = ent_r[rp_r];
  assign stat.vld   = (lvl_r != '0);
  assign stat.level = lvl_r;

endmodule

### hdl/uoha_back.sv
module uoha_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fmt565,
  input  uoha_pkg::job_t             head,
  input  uoha_pkg::q_stat_t          q_stat,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [uoha_pkg::PIX_W-1:0] out_pixel_out,
  output logic [uoha_pkg::OX_W-1:0]  out_x,
  output logic [uoha_pkg::OY_W-1:0]  out_y,
  output logic                       out_last_of_tile
);

  logic                       jv_r, ov_r;
  logic [uoha_pkg::PIX_W-1:0] a_r, b_r, c_r, d_r, ab_r, cd_r, ac_r, bd_r;
  logic [uoha_pkg::OX_W-1:0]  bx_r;
  logic [uoha_pkg::OY_W-1:0]  by_r;
  logic [1:0]                 kc_r, kr_r;
  logic [uoha_pkg::PIX_W-1:0] pix_r;
  logic [uoha_pkg::OX_W-1:0]  ox_r;
  logic [uoha_pkg::OY_W-1:0]  oy_r;
  logic                       last_r;

  logic                       step, tile_end, take;
  logic [uoha_pkg::PIX_W-1:0] center, sel;

  assign step     = jv_r && (!ov_r || pop);
  assign tile_end = (kc_r == 2'd2) && (kr_r == 2'd2);
  assign take     = q_stat.vld && (!jv_r || (step && tile_end));
  assign q_pop    = take;
  assign center   = uoha_pkg::blend(ab_r, cd_r, fmt565);

  always_comb begin
    unique case ({kr_r, kc_r})
      4'b0000: sel = a_r;
      4'b0001: sel = ab_r;
      4'b0010: sel = b_r;
      4'b0100: sel = ac_r;
      4'b0101: sel = center;
      4'b0110: sel = bd_r;
      4'b1000: sel = c_r;
      4'b1001: sel = cd_r;
      4'b1010: sel = d_r;
      default: sel = d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r <= 1'b0;
      ov_r <= 1'b0;
      kc_r <= '0;
      kr_r <= '0;
    end else begin
      if (take) begin
        jv_r <= 1'b1;
      end else if (step && tile_end) begin
        jv_r <= 1'b0;
      end
      if (take) begin
        kc_r <= '0;
        kr_r <= '0;
      end else if (step) begin
        if (kc_r == 2'd2) begin
          kc_r <= '0;
          kr_r <= kr_r + 2'd1;
        end else begin
          kc_r <= kc_r + 2'd1;
        end
      end
      if (step) begin
        ov_r <= 1'b1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  // first level of averages when a tile is taken
  always_ff @(posedge clk) begin
    if (take) begin
      a_r  <= head.a;
      b_r  <= head.b;
      c_r  <= head.c;
      d_r  <= head.d;
      ab_r <= uoha_pkg::blend(head.a, head.b, fmt565);
      cd_r <= uoha_pkg::blend(head.c, head.d, fmt565);
      ac_r <= uoha_pkg::blend(head.a, head.c, fmt565);
      bd_r <= uoha_pkg::blend(head.b, head.d, fmt565);
      bx_r <= head.bx;
      by_r <= head.by;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pix_r  <= sel;
      ox_r   <= bx_r + uoha_pkg::OX_W'(kc_r);
      oy_r   <= by_r + uoha_pkg::OY_W'(kr_r);
      last_r <= tile_end;
    end
  end

  assign empty            = !ov_r;
  assign out_pixel_out    = pix_r;
  assign out_x            = ox_r;
  assign out_y            = oy_r;
  assign out_last_of_tile = last_r;

endmodule

### hdl/upscale_one_and_half_averaging_unit.sv
// 1.5x upscaler: input pixels arrive in raster order (XRGB8888, or RGB565 in the low 16 bits)
// and every 2x2 block becomes a 3x3 tile of originals and rounded averages. One pixel can be
// taken each cycle until the two-entry tile queue fills; the even row goes into a
// MAX_LINE_PIX x 32 line store that is never cleared, and the pixel at an odd row and odd
// column queues a tile. The output sequencer sends one result per cycle while pop keeps up,
// nine per tile, so an odd row is paced by that single result port, while an even row queues
// no tiles and runs at one pixel per cycle once the queue has room, with the result port idle
// once the queue has drained. The pixel that completes a tile passes through the front-end
// tile register, the queue, the tile registers of the output sequencer and its result register.
// A write to the format, width or height register restarts the frame position; trailing
// odd columns and rows give no results.
module upscale_one_and_half_averaging_unit #(
  parameter int MAX_LINE_PIX = 2048,
  parameter int MAX_LINES    = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [uoha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uoha_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [uoha_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                            empty,
  input  logic                            pop,
  output logic [uoha_pkg::PIX_W-1:0]      out_pixel_out,
  output logic [uoha_pkg::OX_W-1:0]       out_x,
  output logic [uoha_pkg::OY_W-1:0]       out_y,
  output logic                            out_last_of_tile
);

  uoha_pkg::job_t    fe_job, q_head;
  uoha_pkg::q_stat_t q_stat;
  logic              fe_push, q_pop, fmt565;

  uoha_front #(
    .MAX_LINE_PIX (MAX_LINE_PIX),
    .MAX_LINES    (MAX_LINES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .in_pixel_in (in_pixel_in),
    .q_stat      (q_stat),
    .job_push    (fe_push),
    .job         (fe_job),
    .fmt565      (fmt565)
  );

  uoha_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (fe_push),
    .wr_job (fe_job),
    .rd     (q_pop),
    .rd_job (q_head),
    .stat   (q_stat)
  );

  uoha_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fmt565           (fmt565),
    .head             (q_head),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_pixel_out    (out_pixel_out),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_last_of_tile (out_last_of_tile)
  );

endmodule

### hdl/uoha_checker.sv
module uoha_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [uoha_pkg::PIX_W-1:0] out_pixel_out,
  input logic [uoha_pkg::OY_W-1:0]  out_y,
  input logic                       out_last_of_tile
);

  // reset leaves nothing to transfer
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("result side not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pixel_out)))
    else $error("waiting result changed");

  // a tile goes out without gaps
  a_tile_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last_of_tile) |=> !empty)
    else $error("gap inside a tile");

  a_tile_row: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last_of_tile) |=>
      (out_y == $past(out_y) || out_y == $past(out_y) + 13'd1))
    else $error("row jump inside a tile");

endmodule

bind upscale_one_and_half_averaging_unit uoha_checker u_uoha_checker (.*);
